// File: rtl/bra_pkg.sv
package bra_pkg;

  localparam int WORD_W     = 32;
  localparam int ACTION_W   = 3;
  localparam int INDEX_W    = 10;
  localparam int LENGTH_W   = 11;
  localparam int START_W    = 10;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR_ALL = 3'd0,
    ACT_TEST      = 3'd1,
    ACT_SET       = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_SEARCH    = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR_ALL,
    OP_TEST,
    OP_SET,
    OP_CLEAR,
    OP_SEARCH
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [INDEX_W-1:0]  bit_index;
    logic [LENGTH_W-1:0] run_length;
  } cmd_t;

  typedef struct packed {
    logic [START_W-1:0] run_start;
    logic               found;
    logic               bit_value;
  } res_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLEAR,
    BK_READ,
    BK_MODIFY,
    BK_SEARCH
  } bk_state_t;

endpackage

// File: rtl/bra_front.sv
module bra_front #(
  parameter int MAP_BYTES = 128
) (
  input  logic                           init_done,
  input  logic                           q_full,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bra_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [bra_pkg::ACTION_W-1:0]   in_tuser,
  output logic                           push,
  output bra_pkg::cmd_t                  push_cmd
);
  import bra_pkg::*;

  localparam int MAP_BITS = MAP_BYTES * 8;

  logic [INDEX_W-1:0]  bit_index;
  logic [LENGTH_W-1:0] run_length;
  logic                idx_ok;
  logic                len_ok;

  assign bit_index  = in_tdata[INDEX_W-1:0];
  assign run_length = in_tdata[INDEX_W+LENGTH_W-1:INDEX_W];
  assign idx_ok     = 32'(bit_index) < 32'(MAP_BITS);
  assign len_ok     = (run_length != '0) && (32'(run_length) <= 32'(MAP_BITS));

  assign in_tready = init_done && !q_full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    push_cmd.bit_index  = bit_index;
    push_cmd.run_length = run_length;
    unique case (in_tuser)
      ACT_CLEAR_ALL: push_cmd.op = OP_CLEAR_ALL;
      ACT_TEST:      push_cmd.op = idx_ok ? OP_TEST : OP_NOP;
      ACT_SET:       push_cmd.op = idx_ok ? OP_SET : OP_NOP;
      ACT_CLEAR:     push_cmd.op = idx_ok ? OP_CLEAR : OP_NOP;
      ACT_SEARCH:    push_cmd.op = len_ok ? OP_SEARCH : OP_NOP;
      default:       push_cmd.op = OP_NOP;
    endcase
  end

endmodule

// File: rtl/bra_queue.sv
module bra_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bra_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output bra_pkg::cmd_t head
);
  import bra_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/bra_back.sv
module bra_back #(
  parameter int MAP_BYTES = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_not_empty,
  input  bra_pkg::cmd_t                   q_head,
  output logic                            pop,
  output logic                            init_done,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bra_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import bra_pkg::*;

  localparam int MAP_BITS  = MAP_BYTES * 8;
  localparam int MAP_WORDS = (MAP_BYTES + 3) / 4;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int NW        = $clog2(MAP_BITS + 64) + 1;
  localparam int LAST_BITS = MAP_BITS - WORD_W * (MAP_WORDS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
  localparam logic [WORD_W-1:0] PAD_MASK = ~((32'h1 << LAST_BITS) - 32'h1);

  logic [WORD_W-1:0] mem [MAP_WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  bk_state_t state_r;
  bk_state_t state_nxt;

  cmd_t          cmd_r;
  cmd_t          cmd_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;
  logic [AW-1:0] scan_addr_r;
  logic [AW-1:0] scan_addr_nxt;
  logic [AW-1:0] eval_addr_r;
  logic [AW-1:0] eval_addr_nxt;
  logic          issue_r;
  logic          issue_nxt;
  logic          dv_r;
  logic          dv_nxt;
  logic [NW-1:0] cnt_r;
  logic [NW-1:0] cnt_nxt;
  logic [NW-1:0] start_r;
  logic [NW-1:0] start_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  res_t          res_r;
  res_t          res_nxt;

  logic              out_free;
  logic              load;
  res_t              load_res;
  logic [AW-1:0]     cmd_word;
  logic [4:0]        cmd_bit;
  logic [WORD_W-1:0] w;
  logic [5:0]        tz;
  logic [5:0]        lz;
  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] len_mask;
  logic [WORD_W-1:0] fit;
  logic [4:0]        fit_pos;
  logic              fit_any;
  logic [NW-1:0]     len_w;
  logic [NW-1:0]     base;
  logic [NW-1:0]     cur_start;
  logic              pre_hit;
  logic              in_hit;
  logic              hit;
  logic [NW-1:0]     hit_start;
  logic              search_done;
  logic              clear_done;

  assign out_free   = !out_valid_r || out_tready;
  assign cmd_word   = AW'(cmd_r.bit_index >> 5);
  assign cmd_bit    = cmd_r.bit_index[4:0];
  assign clear_done = clr_addr_r == LAST_ADDR;
  assign init_done  = state_r != BK_INIT;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), res_r};

  always_comb begin
    w = rd_data_r;
    if (eval_addr_r == LAST_ADDR) begin
      w = rd_data_r | PAD_MASK;
    end
    free_bits = ~w;
    tz = 6'd32;
    lz = 6'd32;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        tz = 6'(i);
      end
    end
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) begin
        lz = 6'(WORD_W - 1 - i);
      end
    end
  end

  always_comb begin
    len_w     = NW'(cmd_r.run_length);
    len_mask  = (len_w >= NW'(WORD_W)) ? '1 : ((32'h1 << len_w[4:0]) - 32'h1);
    base      = NW'(eval_addr_r) << 5;
    cur_start = (cnt_r == '0) ? base : start_r;
    for (int s = 0; s < WORD_W; s++) begin
      fit[s] = ((free_bits >> s) & len_mask) == len_mask;
    end
    fit_pos = '0;
    for (int s = WORD_W - 1; s >= 0; s--) begin
      if (fit[s]) begin
        fit_pos = 5'(s);
      end
    end
    fit_any     = |fit;
    pre_hit     = (cnt_r + NW'(tz)) >= len_w;
    in_hit      = (len_w <= NW'(WORD_W)) && fit_any;
    hit         = pre_hit || in_hit;
    hit_start   = pre_hit ? cur_start : (base + NW'(fit_pos));
    search_done = dv_r && (hit || eval_addr_r == LAST_ADDR);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_INIT: begin
        if (clear_done) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_not_empty && out_free) begin
          unique case (q_head.op) inside
            OP_CLEAR_ALL:              state_nxt = BK_CLEAR;
            OP_TEST, OP_SET, OP_CLEAR: state_nxt = BK_READ;
            OP_SEARCH:                 state_nxt = BK_SEARCH;
            default:                   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_CLEAR: begin
        if (clear_done) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_READ:   state_nxt = BK_MODIFY;
      BK_MODIFY: state_nxt = BK_IDLE;
      BK_SEARCH: begin
        if (search_done) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load     = 1'b0;
    load_res = '0;
    rd_addr  = cmd_word;
    wr_en    = 1'b0;
    wr_addr  = clr_addr_r;
    wr_data  = '0;
    unique case (state_r)
      BK_INIT: begin
        wr_en = 1'b1;
      end
      BK_IDLE: begin
        pop  = q_not_empty && out_free;
        load = pop && (q_head.op == OP_NOP);
      end
      BK_CLEAR: begin
        wr_en = 1'b1;
        load  = clear_done;
      end
      BK_READ: begin
        rd_addr = cmd_word;
      end
      BK_MODIFY: begin
        load    = 1'b1;
        wr_addr = cmd_word;
        wr_data = rd_data_r;
        wr_data[cmd_bit] = cmd_r.op == OP_SET;
        wr_en   = (cmd_r.op == OP_SET) || (cmd_r.op == OP_CLEAR);
        load_res.bit_value = (cmd_r.op == OP_TEST) && rd_data_r[cmd_bit];
      end
      BK_SEARCH: begin
        rd_addr = scan_addr_r;
        load    = search_done;
        load_res.found     = hit;
        load_res.run_start = hit ? START_W'(hit_start) : '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd_nxt       = pop ? q_head : cmd_r;
    clr_addr_nxt  = clr_addr_r;
    scan_addr_nxt = scan_addr_r;
    eval_addr_nxt = eval_addr_r;
    issue_nxt     = issue_r;
    dv_nxt        = 1'b0;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    if (state_r == BK_INIT || state_r == BK_CLEAR) begin
      clr_addr_nxt = clear_done ? '0 : clr_addr_r + AW'(1);
    end
    if (state_r == BK_IDLE) begin
      scan_addr_nxt = '0;
      eval_addr_nxt = '0;
      issue_nxt     = 1'b1;
      cnt_nxt       = '0;
      start_nxt     = '0;
    end
    if (state_r == BK_SEARCH) begin
      if (issue_r) begin
        dv_nxt        = 1'b1;
        eval_addr_nxt = scan_addr_r;
        scan_addr_nxt = scan_addr_r + AW'(1);
        issue_nxt     = scan_addr_r != LAST_ADDR;
      end
      if (dv_r) begin
        if (w == '0) begin
          cnt_nxt   = cnt_r + NW'(WORD_W);
          start_nxt = cur_start;
        end else begin
          cnt_nxt   = NW'(lz);
          start_nxt = base + NW'(WORD_W) - NW'(lz);
        end
      end
    end
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    res_nxt       = load ? load_res : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      clr_addr_r  <= '0;
      issue_r     <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      issue_r     <= issue_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    scan_addr_r <= scan_addr_nxt;
    eval_addr_r <= eval_addr_nxt;
    cnt_r       <= cnt_nxt;
    start_r     <= start_nxt;
    res_r       <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// File: rtl/bitmap_run_allocator.sv
// Test, set and clear pass through the READ and MODIFY states; one item at a time.
// A search walks the map one 32-bit word per cycle over the single memory read port
// and stops early when a run is found.
// Clear-all sweeps the map one word per cycle.
// After reset a clearing pass runs with in_tready held low.
// A two-entry command queue and an output register let both channels stall independently.
module bitmap_run_allocator #(
  parameter int MAP_BYTES = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bra_pkg::IN_DATA_W-1:0]   in_tdata,  // bit_index, run_length
  input  logic [bra_pkg::ACTION_W-1:0]    in_tuser,  // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bra_pkg::OUT_DATA_W-1:0]  out_tdata  // bit_value, found, run_start
);
  import bra_pkg::*;

  logic init_done;
  logic q_full;
  logic q_not_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t q_head;

  bra_front #(
    .MAP_BYTES(MAP_BYTES)
  ) u_front (
    .init_done(init_done),
    .q_full   (q_full),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bra_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  bra_back #(
    .MAP_BYTES(MAP_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .pop        (pop),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
